@@ rtl/idiv_pkg.sv @@
// shared types and constants of the pipelined array divider
package idiv_pkg;

    localparam int DATA_WIDTH = 64;
    localparam int FIELD_WIDTH = 64;
    localparam int OP_WIDTH = 2;

    typedef logic [DATA_WIDTH-1:0] t_word;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_UQUOT = 2'd0,
        OP_UREM  = 2'd1,
        OP_SQUOT = 2'd2,
        OP_SREM  = 2'd3
    } t_op;

    // what the output stage does with the finished quotient and remainder
    typedef struct packed {
        logic sel_rem;
        logic neg;
        logic zero;
    } t_ctl;

endpackage

@@ rtl/idiv_pre.sv @@
// input stage: operand magnitudes and result fix-up flags
module idiv_pre (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [idiv_pkg::OP_WIDTH-1:0]    i_op,
    input  logic [idiv_pkg::FIELD_WIDTH-1:0] i_dividend,
    input  logic [idiv_pkg::FIELD_WIDTH-1:0] i_divisor,
    output logic                         o_valid,
    output idiv_pkg::t_ctl               o_ctl,
    output idiv_pkg::t_word              o_num,
    output idiv_pkg::t_word              o_den
);
    import idiv_pkg::*;

    t_word a;
    t_word b;
    logic  a_neg;
    logic  b_neg;
    logic  is_signed;
    t_op   op;
    t_ctl  n_ctl;
    t_word n_num;
    t_word n_den;

    logic  r_valid;
    t_ctl  r_ctl;
    t_word r_num;
    t_word r_den;

    always_comb begin
        op        = t_op'(i_op);
        a         = i_dividend[DATA_WIDTH-1:0];
        b         = i_divisor[DATA_WIDTH-1:0];
        a_neg     = a[DATA_WIDTH-1];
        b_neg     = b[DATA_WIDTH-1];
        is_signed = (op == OP_SQUOT) || (op == OP_SREM);
        n_num     = (is_signed && a_neg) ? (t_word'(0) - a) : a;
        n_den     = (is_signed && b_neg) ? (t_word'(0) - b) : b;
        n_ctl.sel_rem = (op == OP_UREM) || (op == OP_SREM);
        n_ctl.zero    = (b == t_word'(0));
        unique case (op)
            OP_SQUOT: n_ctl.neg = a_neg ^ b_neg;
            OP_SREM:  n_ctl.neg = a_neg;
            default:  n_ctl.neg = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl <= n_ctl;
            r_num <= n_num;
            r_den <= n_den;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_num   = r_num;
    assign o_den   = r_den;

endmodule

@@ rtl/idiv_cell.sv @@
// one restoring division step: shift in a dividend bit, trial subtract
module idiv_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  idiv_pkg::t_ctl  i_ctl,
    input  idiv_pkg::t_word i_rem,
    input  idiv_pkg::t_word i_nq,   // dividend bits left, quotient bits shifted in below
    input  idiv_pkg::t_word i_den,
    output logic            o_valid,
    output idiv_pkg::t_ctl  o_ctl,
    output idiv_pkg::t_word o_rem,
    output idiv_pkg::t_word o_nq,
    output idiv_pkg::t_word o_den
);
    import idiv_pkg::*;

    t_word                 shifted;
    logic [DATA_WIDTH:0]   diff;
    logic                  ge;
    t_word                 n_rem;
    t_word                 n_nq;

    logic  r_valid;
    t_ctl  r_ctl;
    t_word r_rem;
    t_word r_nq;
    t_word r_den;

    always_comb begin
        // the partial remainder keeps only its low bits when shifted
        shifted = {i_rem[DATA_WIDTH-2:0], i_nq[DATA_WIDTH-1]};
        diff    = {1'b0, shifted} - {1'b0, i_den};
        ge      = !diff[DATA_WIDTH];
        n_rem   = ge ? diff[DATA_WIDTH-1:0] : shifted;
        n_nq    = {i_nq[DATA_WIDTH-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl <= i_ctl;
            r_rem <= n_rem;
            r_nq  <= n_nq;
            r_den <= i_den;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_rem   = r_rem;
    assign o_nq    = r_nq;
    assign o_den   = r_den;

endmodule

@@ rtl/idiv_post.sv @@
// output stage: select, sign fix, zero-divisor override, output register and skid register
module idiv_post (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  idiv_pkg::t_ctl  i_ctl,
    input  idiv_pkg::t_word i_rem,
    input  idiv_pkg::t_word i_quot,
    input  logic            i_ready,
    output logic            o_en,
    output logic            o_valid,
    output idiv_pkg::t_word o_result
);
    import idiv_pkg::*;

    t_word sel;
    t_word n_res;

    logic  r_out_valid;
    t_word r_out;
    logic  r_skid_valid;
    t_word r_skid;
    logic  en;

    always_comb begin
        sel   = i_ctl.sel_rem ? i_rem : i_quot;
        n_res = i_ctl.neg ? (t_word'(0) - sel) : sel;
        if (i_ctl.zero) begin
            n_res = '0;
        end
    end

    // the pipeline moves whenever the skid register is free
    assign en = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (en) begin
                r_out_valid  <= i_valid;
                r_skid_valid <= r_out_valid && !i_ready;
            end else if (i_ready) begin
                r_skid_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out  <= n_res;
            r_skid <= r_out;
        end
    end

    assign o_en     = en;
    assign o_valid  = r_skid_valid || r_out_valid;
    assign o_result = r_skid_valid ? r_skid : r_out;

endmodule

@@ rtl/int64_divider_signed_unsigned.sv @@
// top level: 64-bit signed/unsigned restoring array divider
// path to m_axis_tvalid: input stage register, one register per division cell, output register
// throughput: one request per cycle while s_axis_tready is high, set by the row of DATA_WIDTH division cells,
//   each doing one shift and trial subtract of one quotient bit
// a skid register behind the output register lets the pipeline take a request even as
//   the consumer first stalls; s_axis_tready then drops until it drains
// reset: synchronous active low, empties every stage; s_axis_tready is high after reset
module int64_divider_signed_unsigned (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // [63:0] dividend, [127:64] divisor
    input  logic [1:0]   s_axis_tuser,   // [1:0] op
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata    // [63:0] result
);
    import idiv_pkg::*;

    // pipeline advance, common to every stage
    logic en;

    // chain links: index 0 is the input stage, index k+1 is after cell k
    logic  v_valid [DATA_WIDTH+1];
    t_ctl  v_ctl   [DATA_WIDTH+1];
    t_word v_rem   [DATA_WIDTH+1];
    t_word v_nq    [DATA_WIDTH+1];
    t_word v_den   [DATA_WIDTH+1];

    t_word result;

    // magnitudes of the operands and the flags for the final sign fix
    idiv_pre u_pre (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (s_axis_tvalid),
        .i_op       (s_axis_tuser),
        .i_dividend (s_axis_tdata[FIELD_WIDTH-1:0]),
        .i_divisor  (s_axis_tdata[2*FIELD_WIDTH-1:FIELD_WIDTH]),
        .o_valid    (v_valid[0]),
        .o_ctl      (v_ctl[0]),
        .o_num      (v_nq[0]),
        .o_den      (v_den[0])
    );

    // partial remainder starts at zero
    assign v_rem[0] = '0;

    // one cell per quotient bit, top bit first; the dividend leaves the
    // shared register at the top as the quotient enters at the bottom
    for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_cell
        idiv_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v_valid[k]),
            .i_ctl   (v_ctl[k]),
            .i_rem   (v_rem[k]),
            .i_nq    (v_nq[k]),
            .i_den   (v_den[k]),
            .o_valid (v_valid[k+1]),
            .o_ctl   (v_ctl[k+1]),
            .o_rem   (v_rem[k+1]),
            .o_nq    (v_nq[k+1]),
            .o_den   (v_den[k+1])
        );
    end

    // quotient/remainder select, negate, zero-divisor override, skid
    idiv_post u_post (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (v_valid[DATA_WIDTH]),
        .i_ctl    (v_ctl[DATA_WIDTH]),
        .i_rem    (v_rem[DATA_WIDTH]),
        .i_quot   (v_nq[DATA_WIDTH]),
        .i_ready  (m_axis_tready),
        .o_en     (en),
        .o_valid  (m_axis_tvalid),
        .o_result (result)
    );

    assign s_axis_tready = en;
    // bits above the data width read as zero
    assign m_axis_tdata  = FIELD_WIDTH'(result);

endmodule

@@ rtl/idiv_chk.sv @@
// port-level checker for the divider, bound to the top level
module idiv_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [63:0]  m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed or dropped while stalled");

    // input back-pressure only comes from a waiting result
    a_bp_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("request refused with no result pending");

    // a taken result frees the skid register
    a_bp_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |=> s_axis_tready)
        else $error("request side still stalled after result was taken");

    // right out of reset the pipe is empty and open
    a_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> s_axis_tready && !m_axis_tvalid)
        else $error("pipeline not empty after reset");

endmodule

bind int64_divider_signed_unsigned idiv_chk u_idiv_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
